// ===== rtl/c8_pkg.sv =====
// ----------------------------------------------------------------------------
// c8_pkg
// shared constants and types for the chip-8 interpreter core
// ----------------------------------------------------------------------------
package c8_pkg;

  localparam int MemBytes     = 4096;
  localparam int AddrW        = $clog2(MemBytes);
  localparam int FbGroups     = 256;
  localparam int FbAddrW      = $clog2(FbGroups);
  localparam int StackDepth   = 16;
  localparam int SpW          = $clog2(StackDepth);
  localparam int InDataW      = 56;
  localparam int OutDataW     = 40;

  localparam logic [AddrW-1:0] PcReset = 12'h200;

  // request kinds carried in tuser
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_EXEC = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;
  localparam logic [1:0] REQ_READ = 2'd3;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;
  localparam logic [7:0]  KK_SKP = 8'h9E;
  localparam logic [7:0]  KK_SKNP = 8'hA1;
  localparam logic [7:0]  KK_LDDT = 8'h07;
  localparam logic [7:0]  KK_WKEY = 8'h0A;
  localparam logic [7:0]  KK_SETDT = 8'h15;
  localparam logic [7:0]  KK_SETST = 8'h18;
  localparam logic [7:0]  KK_ADDI = 8'h1E;
  localparam logic [7:0]  KK_FONT = 8'h29;
  localparam logic [7:0]  KK_BCD = 8'h33;
  localparam logic [7:0]  KK_STORE = 8'h55;
  localparam logic [7:0]  KK_LOADR = 8'h65;

  typedef logic [7:0] byte_t;

endpackage

// ===== rtl/c8_ram.sv =====
// ----------------------------------------------------------------------------
// c8_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/chip8_interpreter_core_top.sv =====
// ----------------------------------------------------------------------------
// chip8_interpreter_core_top
// chip-8 core: memory load, single-step execute, timer tick, display read
// ----------------------------------------------------------------------------
// One item is handled at a time; the next is taken once the core is back in
// idle. A plain instruction goes through fetch (S_F0, S_F1, S_F2 through the
// single memory port), two register reads, execute and result; a block store
// or load works through the registers one at a time, BCD by repeated
// subtraction, and a sprite draw row by row, since each row needs a memory
// read and up to two read-modify-write passes on the display ram. Results
// wait in an output register. The display is cleared at once by reset and by
// the clear instruction through per-group valid bits.
module chip8_interpreter_core_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // load_address[11:0], load_byte[19:12], key_mask[35:20], random_byte[43:36],
  // pixel_group[51:44], zero pad
  input  logic [c8_pkg::InDataW-1:0]   s_tdata,
  // req_type[1:0]
  input  logic [1:0]                   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // program_counter[11:0], executed_opcode[27:12], draw_done[28], beep[29],
  // waiting_key[30], pixel_bits[38:31], zero pad
  output logic [c8_pkg::OutDataW-1:0]  m_tdata
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_LOAD = 5'd1;
  localparam logic [4:0] S_TICK = 5'd2;
  localparam logic [4:0] S_RD   = 5'd3;
  localparam logic [4:0] S_RDW  = 5'd4;
  localparam logic [4:0] S_F0   = 5'd5;
  localparam logic [4:0] S_F1   = 5'd6;
  localparam logic [4:0] S_F2   = 5'd7;
  localparam logic [4:0] S_RX   = 5'd8;
  localparam logic [4:0] S_RY   = 5'd9;
  localparam logic [4:0] S_EX   = 5'd10;
  localparam logic [4:0] D_RD   = 5'd11;
  localparam logic [4:0] D_SP   = 5'd12;
  localparam logic [4:0] D_W0   = 5'd13;
  localparam logic [4:0] D_R1   = 5'd14;
  localparam logic [4:0] D_W1   = 5'd15;
  localparam logic [4:0] B_HUN  = 5'd16;
  localparam logic [4:0] B_TEN  = 5'd17;
  localparam logic [4:0] B_ONE  = 5'd18;
  localparam logic [4:0] M_ST   = 5'd19;
  localparam logic [4:0] M_LD   = 5'd20;
  localparam logic [4:0] M_LDW  = 5'd21;
  localparam logic [4:0] S_DONE = 5'd22;

  logic [4:0] state;

  logic [c8_pkg::AddrW-1:0] ld_addr;
  c8_pkg::byte_t            ld_byte;
  logic [15:0]              keys;
  c8_pkg::byte_t            rnd;
  logic [7:0]               pgrp;

  logic [c8_pkg::AddrW-1:0] pc;
  logic [15:0]              opcode;
  logic [15:0]              idx;
  c8_pkg::byte_t            regs [16];
  logic [c8_pkg::AddrW-1:0] stk [c8_pkg::StackDepth];
  logic [c8_pkg::SpW-1:0]   sp;
  c8_pkg::byte_t            dly;
  c8_pkg::byte_t            snd;
  c8_pkg::byte_t            vx;
  c8_pkg::byte_t            vy;
  c8_pkg::byte_t            hi_byte;
  c8_pkg::byte_t            spr;
  logic [3:0]               row_cnt;
  logic                     hit;
  logic [3:0]               cnt;
  logic [3:0]               dig;
  c8_pkg::byte_t            rem;
  logic                     drew_f;
  logic                     beep_f;
  logic                     wait_f;
  c8_pkg::byte_t            pix_f;

  logic [c8_pkg::FbGroups-1:0] fb_valid;
  logic                        fb_rv;

  // memory ports
  logic                      mem_we;
  logic [c8_pkg::AddrW-1:0]  mem_addr;
  c8_pkg::byte_t             mem_wd;
  c8_pkg::byte_t             mem_rd;
  logic                      fb_we;
  logic [c8_pkg::FbAddrW-1:0] fb_addr;
  c8_pkg::byte_t             fb_wd;
  c8_pkg::byte_t             fb_rd;

  c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::MemBytes)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wd),
    .rdata (mem_rd)
  );

  c8_ram #(.WIDTH(8), .DEPTH(c8_pkg::FbGroups)) u_fb (
    .clk   (clk),
    .we    (fb_we),
    .addr  (fb_addr),
    .wdata (fb_wd),
    .rdata (fb_rd)
  );

  // decoded fields
  logic [3:0]               op_x;
  logic [3:0]               op_y;
  logic [3:0]               op_n;
  c8_pkg::byte_t            op_kk;
  logic [c8_pkg::AddrW-1:0] op_nnn;
  assign op_x   = opcode[11:8];
  assign op_y   = opcode[7:4];
  assign op_n   = opcode[3:0];
  assign op_kk  = opcode[7:0];
  assign op_nnn = opcode[11:0];

  logic [c8_pkg::AddrW-1:0] pc_inc;
  logic [c8_pkg::AddrW-1:0] idx_lo;
  assign pc_inc = pc + 12'd2;
  assign idx_lo = idx[c8_pkg::AddrW-1:0];

  logic [c8_pkg::SpW-1:0] sp_dec;
  logic [c8_pkg::SpW-1:0] sp_inc;
  assign sp_dec = (sp == '0) ? c8_pkg::SpW'(c8_pkg::StackDepth - 1) : sp - 1'b1;
  assign sp_inc = (sp == c8_pkg::SpW'(c8_pkg::StackDepth - 1)) ? '0 : sp + 1'b1;

  // sprite geometry
  logic [5:0] row_sum;
  logic [4:0] row;
  logic [2:0] g0;
  logic [2:0] sh;
  c8_pkg::byte_t mask0;
  c8_pkg::byte_t mask1;
  c8_pkg::byte_t fb_old;
  c8_pkg::byte_t mask_cur;
  assign row_sum  = {1'b0, vy[4:0]} + {2'b0, row_cnt};
  assign row      = row_sum[4:0];
  assign g0       = vx[5:3];
  assign sh       = vx[2:0];
  assign mask0    = spr >> sh;
  assign mask1    = spr << (3'd0 - sh);
  assign fb_old   = fb_rv ? fb_rd : 8'd0;
  assign mask_cur = (state == D_W1) ? mask1 : mask0;

  // shared compare-subtract for bcd digits
  c8_pkg::byte_t bcd_k;
  logic          bcd_ge;
  assign bcd_k  = (state == B_HUN) ? 8'd100 : 8'd10;
  assign bcd_ge = rem >= bcd_k;

  // lowest pressed key
  logic       key_any;
  logic [3:0] key_idx;
  always_comb begin
    key_any = 1'b0;
    key_idx = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys[k]) begin
        key_any = 1'b1;
        key_idx = 4'(k);
      end
    end
  end

  logic key_dn;
  assign key_dn = (vx[7:4] == 4'd0) && keys[vx[3:0]];

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = pc;
    mem_wd   = ld_byte;
    fb_we    = 1'b0;
    fb_addr  = {row, g0};
    fb_wd    = fb_old ^ mask_cur;
    unique case (state)
      S_LOAD: begin
        mem_we   = 1'b1;
        mem_addr = ld_addr;
      end
      S_F1:   mem_addr = pc + 12'd1;
      D_RD:   mem_addr = idx_lo + {8'd0, row_cnt};
      B_HUN: begin
        mem_we   = !bcd_ge;
        mem_addr = idx_lo;
        mem_wd   = {4'd0, dig};
      end
      B_TEN: begin
        mem_we   = !bcd_ge;
        mem_addr = idx_lo + 12'd1;
        mem_wd   = {4'd0, dig};
      end
      B_ONE: begin
        mem_we   = 1'b1;
        mem_addr = idx_lo + 12'd2;
        mem_wd   = rem;
      end
      M_ST: begin
        mem_we   = 1'b1;
        mem_addr = idx_lo + {8'd0, cnt};
        mem_wd   = regs[cnt];
      end
      M_LD:   mem_addr = idx_lo + {8'd0, cnt};
      S_RD:   fb_addr = pgrp;
      D_W0:   fb_we = 1'b1;
      D_R1:   fb_addr = {row, g0 + 3'd1};
      D_W1: begin
        fb_we   = 1'b1;
        fb_addr = {row, g0 + 3'd1};
      end
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pc       <= c8_pkg::PcReset;
      opcode   <= '0;
      idx      <= '0;
      sp       <= '0;
      dly      <= '0;
      snd      <= '0;
      fb_valid <= '0;
      fb_rv    <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        regs[i] <= '0;
      end
      for (int i = 0; i < c8_pkg::StackDepth; i++) begin
        stk[i] <= '0;
      end
    end else begin
      fb_rv <= fb_valid[fb_addr];
      if (fb_we) begin
        fb_valid[fb_addr] <= 1'b1;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ld_addr <= s_tdata[11:0];
            ld_byte <= s_tdata[19:12];
            keys    <= s_tdata[35:20];
            rnd     <= s_tdata[43:36];
            pgrp    <= s_tdata[51:44];
            drew_f  <= 1'b0;
            beep_f  <= 1'b0;
            wait_f  <= 1'b0;
            pix_f   <= '0;
            unique case (s_tuser)
              c8_pkg::REQ_LOAD: state <= S_LOAD;
              c8_pkg::REQ_EXEC: state <= S_F0;
              c8_pkg::REQ_TICK: state <= S_TICK;
              c8_pkg::REQ_READ: state <= S_RD;
              default:          state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: state <= S_DONE;
        S_TICK: begin
          if (dly != 8'd0) begin
            dly <= dly - 8'd1;
          end
          if (snd != 8'd0) begin
            snd    <= snd - 8'd1;
            beep_f <= (snd == 8'd1);
          end
          state <= S_DONE;
        end
        S_RD:  state <= S_RDW;
        S_RDW: begin
          pix_f <= fb_old;
          state <= S_DONE;
        end
        S_F0: state <= S_F1;
        S_F1: begin
          hi_byte <= mem_rd;
          state   <= S_F2;
        end
        S_F2: begin
          opcode <= {hi_byte, mem_rd};
          pc     <= pc_inc;
          state  <= S_RX;
        end
        S_RX: begin
          vx    <= regs[op_x];
          state <= S_RY;
        end
        S_RY: begin
          vy    <= regs[op_y];
          state <= S_EX;
        end
        S_EX: begin
          state <= S_DONE;
          unique case (opcode[15:12])
            4'h0: begin
              if (opcode == c8_pkg::OP_CLS) begin
                fb_valid <= '0;
              end else if (opcode == c8_pkg::OP_RET) begin
                sp <= sp_dec;
                pc <= stk[sp_dec];
              end
            end
            4'h1: pc <= op_nnn;
            4'h2: begin
              stk[sp] <= pc;
              sp      <= sp_inc;
              pc      <= op_nnn;
            end
            4'h3: if (vx == op_kk) pc <= pc_inc;
            4'h4: if (vx != op_kk) pc <= pc_inc;
            4'h5: if (vx == vy) pc <= pc_inc;
            4'h6: regs[op_x] <= op_kk;
            4'h7: regs[op_x] <= vx + op_kk;
            4'h8: begin
              // flag first so that a result in vf wins
              unique case (op_n)
                4'h0: regs[op_x] <= vy;
                4'h1: regs[op_x] <= vx | vy;
                4'h2: regs[op_x] <= vx & vy;
                4'h3: regs[op_x] <= vx ^ vy;
                4'h4: begin
                  regs[15]   <= {7'd0, 9'({1'b0, vx} + {1'b0, vy}) > 9'd255};
                  regs[op_x] <= vx + vy;
                end
                4'h5: begin
                  regs[15]   <= {7'd0, vx > vy};
                  regs[op_x] <= vx - vy;
                end
                4'h6: begin
                  regs[15]   <= {7'd0, vx[0]};
                  regs[op_x] <= vx >> 1;
                end
                4'h7: begin
                  regs[15]   <= {7'd0, vy > vx};
                  regs[op_x] <= vy - vx;
                end
                4'hE: begin
                  regs[15]   <= {7'd0, vx[7]};
                  regs[op_x] <= vx << 1;
                end
                default: ;
              endcase
            end
            4'h9: if (op_n == 4'd0 && vx != vy) pc <= pc_inc;
            4'hA: idx <= {4'd0, op_nnn};
            4'hB: pc <= op_nnn + {4'd0, regs[0]};
            4'hC: regs[op_x] <= rnd & op_kk;
            4'hD: begin
              hit     <= 1'b0;
              row_cnt <= '0;
              state   <= D_RD;
            end
            4'hE: begin
              if (op_kk == c8_pkg::KK_SKP && key_dn) begin
                pc <= pc_inc;
              end else if (op_kk == c8_pkg::KK_SKNP && !key_dn) begin
                pc <= pc_inc;
              end
            end
            default: begin
              unique case (op_kk)
                c8_pkg::KK_LDDT:  regs[op_x] <= dly;
                c8_pkg::KK_WKEY: begin
                  if (key_any) begin
                    regs[op_x] <= {4'd0, key_idx};
                  end else begin
                    pc     <= pc - 12'd2;
                    wait_f <= 1'b1;
                  end
                end
                c8_pkg::KK_SETDT: dly <= vx;
                c8_pkg::KK_SETST: snd <= vx;
                c8_pkg::KK_ADDI:  idx <= idx + {8'd0, vx};
                c8_pkg::KK_FONT:  idx <= {6'd0, vx, 2'b00} + {8'd0, vx};
                c8_pkg::KK_BCD: begin
                  rem   <= vx;
                  dig   <= '0;
                  state <= B_HUN;
                end
                c8_pkg::KK_STORE: begin
                  cnt   <= '0;
                  state <= M_ST;
                end
                c8_pkg::KK_LOADR: begin
                  cnt   <= '0;
                  state <= M_LD;
                end
                default: ;
              endcase
            end
          endcase
        end
        D_RD: begin
          if (row_cnt == op_n || row_sum[5]) begin
            regs[15] <= {7'd0, hit};
            drew_f   <= 1'b1;
            state    <= S_DONE;
          end else begin
            state <= D_SP;
          end
        end
        D_SP: begin
          spr   <= mem_rd;
          state <= D_W0;
        end
        D_W0: begin
          hit <= hit | (|(fb_old & mask0));
          // right part lands in the next group unless clipped at the edge
          if (sh != 3'd0 && g0 != 3'd7) begin
            state <= D_R1;
          end else begin
            row_cnt <= row_cnt + 4'd1;
            state   <= D_RD;
          end
        end
        D_R1: state <= D_W1;
        D_W1: begin
          hit     <= hit | (|(fb_old & mask1));
          row_cnt <= row_cnt + 4'd1;
          state   <= D_RD;
        end
        B_HUN, B_TEN: begin
          if (bcd_ge) begin
            rem <= rem - bcd_k;
            dig <= dig + 4'd1;
          end else begin
            dig   <= '0;
            state <= (state == B_HUN) ? B_TEN : B_ONE;
          end
        end
        B_ONE: state <= S_DONE;
        M_ST: begin
          if (cnt == op_x) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        M_LD: state <= M_LDW;
        M_LDW: begin
          regs[cnt] <= mem_rd;
          if (cnt == op_x) begin
            state <= S_DONE;
          end else begin
            cnt   <= cnt + 4'd1;
            state <= M_LD;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, pix_f, wait_f, beep_f, drew_f, opcode, pc};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("core took an item while busy");

  a_fb_write_in_draw: assert property (@(posedge clk) disable iff (rst)
    fb_we |-> (state == D_W0 || state == D_W1))
    else $error("display write outside a draw");

  a_wait_only_wkey: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[30]) |-> (m_tdata[27:24] == 4'hF && m_tdata[19:12] == 8'h0A))
    else $error("waiting flag without a wait-for-key opcode");

  a_draw_only_dxyn: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[28]) |-> (m_tdata[27:24] == 4'hD))
    else $error("draw flag without a draw opcode");

endmodule

// ===== tb/chip8_checker.sv =====
// ----------------------------------------------------------------------------
// chip8_checker
// watches both streams of the chip-8 core, predicts every result and compares
// ----------------------------------------------------------------------------
module chip8_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [c8_pkg::InDataW-1:0]  s_tdata,
  input  logic [1:0]                  s_tuser,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [c8_pkg::OutDataW-1:0] m_tdata,
  output int                          fail_count,
  output int                          pending,
  output int                          result_count,
  output int                          draw_count,
  output int                          beep_count
);

  typedef struct packed {
    logic [7:0]  pix;
    logic        wait_key;
    logic        beep;
    logic        drew;
    logic [15:0] opcode;
    logic [11:0] pc;
  } core_result_t;

  c8_pkg::byte_t          mem [c8_pkg::MemBytes];
  c8_pkg::byte_t          vreg [16];
  logic [11:0]            ret_stack [c8_pkg::StackDepth];
  logic [c8_pkg::SpW-1:0] sp;
  logic [15:0]            ireg;
  logic [11:0]            pc;
  logic                   screen [2048];
  c8_pkg::byte_t          delay_cnt, sound_cnt;
  logic [15:0]            last_op;
  core_result_t           expected_results [$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic logic [11:0] pc_plus2(input logic [11:0] p);
    return p + 12'd2;
  endfunction

  task automatic reset_model();
    foreach (vreg[i]) vreg[i] = '0;
    foreach (ret_stack[i]) ret_stack[i] = '0;
    foreach (screen[i]) screen[i] = 1'b0;
    sp = '0; ireg = '0; pc = c8_pkg::PcReset; delay_cnt = '0; sound_cnt = '0;
    last_op = '0;
    expected_results.delete();
  endtask

  task automatic run_instr(input logic [15:0] keys, input c8_pkg::byte_t rnd,
                           output logic drew, output logic wk);
    logic [15:0]   op;
    logic [3:0]    x, y, n;
    c8_pkg::byte_t kk, vx, vy, bits;
    logic [11:0]   nnn;
    logic [8:0]    s;
    int            x0, y0, k;
    logic          hit;
    op = {mem[pc], mem[pc + 12'd1]};
    x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0]; nnn = op[11:0];
    drew = 0; wk = 0;
    last_op = op;
    pc = pc_plus2(pc);
    vx = vreg[x]; vy = vreg[y];
    case (op[15:12])
      4'h0: begin
        if (op == c8_pkg::OP_CLS) begin
          foreach (screen[i]) screen[i] = 1'b0;
        end else if (op == c8_pkg::OP_RET) begin
          sp = sp - 1'b1;
          pc = ret_stack[sp];
        end
      end
      4'h1: pc = nnn;
      4'h2: begin
        ret_stack[sp] = pc; sp = sp + 1'b1; pc = nnn;
      end
      4'h3: if (vx == kk) pc = pc_plus2(pc);
      4'h4: if (vx != kk) pc = pc_plus2(pc);
      4'h5: if (vx == vy) pc = pc_plus2(pc);
      4'h6: vreg[x] = kk;
      4'h7: vreg[x] = vx + kk;
      4'h8: begin
        case (n)
          4'h0: vreg[x] = vy;
          4'h1: vreg[x] = vx | vy;
          4'h2: vreg[x] = vx & vy;
          4'h3: vreg[x] = vx ^ vy;
          4'h4: begin s = {1'b0, vx} + {1'b0, vy}; vreg[15] = {7'd0, s[8]}; vreg[x] = s[7:0]; end
          4'h5: begin vreg[15] = {7'd0, vx > vy}; vreg[x] = vx - vy; end
          4'h6: begin vreg[15] = {7'd0, vx[0]}; vreg[x] = vx >> 1; end
          4'h7: begin vreg[15] = {7'd0, vy > vx}; vreg[x] = vy - vx; end
          4'hE: begin vreg[15] = {7'd0, vx[7]}; vreg[x] = vx << 1; end
          default: ;
        endcase
      end
      4'h9: if (n == 4'd0 && vx != vy) pc = pc_plus2(pc);
      4'hA: ireg = {4'h0, nnn};
      4'hB: pc = nnn + {4'h0, vreg[0]};
      4'hC: vreg[x] = rnd & kk;
      4'hD: begin
        x0 = int'(vx) % 64; y0 = int'(vy) % 32; hit = 0;
        for (int r = 0; r < int'(n); r++) begin
          bits = mem[12'(ireg + r)];
          if (y0 + r < 32) begin
            for (int c = 0; c < 8; c++) begin
              if (x0 + c < 64 && bits[7-c]) begin
                if (screen[(y0 + r) * 64 + x0 + c]) hit = 1;
                screen[(y0 + r) * 64 + x0 + c] ^= 1'b1;
              end
            end
          end
        end
        vreg[15] = {7'd0, hit}; drew = 1;
      end
      4'hE: begin
        if (kk == c8_pkg::KK_SKP && vx < 16 && keys[vx[3:0]]) pc = pc_plus2(pc);
        else if (kk == c8_pkg::KK_SKNP && !(vx < 16 && keys[vx[3:0]])) pc = pc_plus2(pc);
      end
      default: begin
        case (kk)
          c8_pkg::KK_LDDT: vreg[x] = delay_cnt;
          c8_pkg::KK_WKEY: begin
            k = 16;
            for (int i = 15; i >= 0; i--) if (keys[i]) k = i;
            if (k < 16) vreg[x] = 8'(k);
            else begin pc = pc - 12'd2; wk = 1; end
          end
          c8_pkg::KK_SETDT: delay_cnt = vx;
          c8_pkg::KK_SETST: sound_cnt = vx;
          c8_pkg::KK_ADDI: ireg = ireg + {8'h0, vx};
          c8_pkg::KK_FONT: ireg = 16'(int'(vx) * 5);
          c8_pkg::KK_BCD: begin
            mem[12'(ireg)] = 8'(vx / 100);
            mem[12'(ireg + 1)] = 8'((vx / 10) % 10);
            mem[12'(ireg + 2)] = 8'(vx % 10);
          end
          c8_pkg::KK_STORE: for (int i = 0; i <= int'(x); i++) mem[12'(ireg + i)] = vreg[i];
          c8_pkg::KK_LOADR: for (int i = 0; i <= int'(x); i++) vreg[i] = mem[12'(ireg + i)];
          default: ;
        endcase
      end
    endcase
  endtask

  task automatic predict_item(input logic [1:0] kind, input logic [c8_pkg::InDataW-1:0] d);
    core_result_t r;
    logic drew, wk;
    int base;
    r = '0;
    case (kind)
      c8_pkg::REQ_LOAD: mem[d[11:0]] = d[19:12];
      c8_pkg::REQ_EXEC: begin
        run_instr(d[35:20], d[43:36], drew, wk);
        r.drew = drew; r.wait_key = wk;
      end
      c8_pkg::REQ_TICK: begin
        if (delay_cnt > 0) delay_cnt--;
        if (sound_cnt > 0) begin
          sound_cnt--;
          if (sound_cnt == 0) r.beep = 1;
        end
      end
      default: begin
        base = int'(d[51:47]) * 64 + int'(d[46:44]) * 8;
        for (int c = 0; c < 8; c++) r.pix[7-c] = screen[base + c];
      end
    endcase
    r.pc = pc; r.opcode = last_op;
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    core_result_t got, want;
    if (rst) begin
      reset_model();
      fail_count = 0; result_count = 0; draw_count = 0; beep_count = 0;
      pending = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[38:0];
        result_count++;
        if (expected_results.size() == 0) begin
          report("unexpected item", got, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.pc != want.pc) report("program_counter", got.pc, want.pc);
          if (got.opcode != want.opcode) report("executed_opcode", got.opcode, want.opcode);
          if (got.drew != want.drew) report("draw_done", got.drew, want.drew);
          if (got.beep != want.beep) report("beep", got.beep, want.beep);
          if (got.wait_key != want.wait_key) report("waiting_key", got.wait_key, want.wait_key);
          if (got.pix != want.pix) report("pixel_bits", got.pix, want.pix);
          draw_count += int'(want.drew);
          beep_count += int'(want.beep);
        end
      end
      // predict after popping so an item and its result in one edge stay ordered
      if (s_tvalid && s_tready) predict_item(s_tuser, s_tdata);
      pending = expected_results.size();
    end
  end
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the chip-8 core: directed programs, then random
// well-formed programs run from written memory with ticks, reads and idling
// ----------------------------------------------------------------------------
module tb;

  logic                        clk, rst;
  logic                        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [c8_pkg::InDataW-1:0]  s_tdata;
  logic [1:0]                  s_tuser;
  logic [c8_pkg::OutDataW-1:0] m_tdata;
  int fail_count, pending, result_count, draw_count, beep_count;
  int cycles;
  int n_items;
  bit rx_idle_on;
  bit written [c8_pkg::MemBytes];

  chip8_interpreter_core_top u_top (.*);

  chip8_checker u_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready,
    .m_tdata, .fail_count, .pending, .result_count, .draw_count, .beep_count
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 900000) begin
        $display("timeout after %0d cycles", cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver stall bursts
  initial begin
    m_tready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [11:0] addr,
                           input c8_pkg::byte_t b, input logic [15:0] keys,
                           input c8_pkg::byte_t rnd, input c8_pkg::byte_t grp,
                           input bit gaps);
    if (gaps && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'h0, grp, rnd, keys, b, addr};
    @(posedge clk iff s_tready);
    n_items++;
    if (kind == c8_pkg::REQ_LOAD) written[addr] = 1;
  endtask

  task automatic load_byte(input logic [11:0] a, input c8_pkg::byte_t b, input bit gaps);
    send_item(c8_pkg::REQ_LOAD, a, b, 16'($urandom), 8'($urandom), 8'($urandom), gaps);
  endtask

  // make every byte a memory-reading instruction may touch written
  task automatic fill_span(input logic [11:0] a, input int len, input bit gaps);
    for (int i = 0; i < len; i++)
      if (!written[12'(a + i)]) load_byte(12'(a + i), 8'($urandom), gaps);
  endtask

  // write the opcode at pc and step it; pc is tracked here to place code
  logic [11:0] cur_pc;

  task automatic exec_op(input logic [15:0] op, input logic [15:0] keys, input bit gaps);
    load_byte(cur_pc, op[15:8], gaps);
    load_byte(cur_pc + 12'd1, op[7:0], gaps);
    // sprite rows and block loads read memory at i
    if (op[15:12] == 4'hD) begin
      fill_span(u_chk.ireg[11:0], int'(op[3:0]), gaps);
    end else if (op[15:12] == 4'hF && op[7:0] == c8_pkg::KK_LOADR) begin
      fill_span(u_chk.ireg[11:0], int'(op[11:8]) + 1, gaps);
    end
    send_item(c8_pkg::REQ_EXEC, 12'($urandom), 8'($urandom), keys, 8'($urandom),
              8'($urandom), gaps);
    s_tvalid <= 1'b0;
    // follow pc from the core's result once everything has drained
    @(posedge clk iff pending == 0);
    cur_pc = m_tdata[11:0];
  endtask

  task automatic tick(input bit gaps);
    send_item(c8_pkg::REQ_TICK, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom), gaps);
  endtask

  task automatic read_px(input c8_pkg::byte_t g, input bit gaps);
    send_item(c8_pkg::REQ_READ, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
              g, gaps);
  endtask

  function automatic logic [15:0] random_op();
    logic [15:0] op;
    op = 16'($urandom);
    case ($urandom_range(0, 15))
      0:  op = $urandom_range(0, 1) ? c8_pkg::OP_CLS : c8_pkg::OP_RET;
      1:  op = {4'h6, op[11:0]};
      2:  op = {4'h8, op[11:4], 4'($urandom_range(0, 7))};
      3:  op = {4'h8, op[11:4], 4'hE};
      4:  op = {4'hF, op[11:8], c8_pkg::KK_SETST};
      5:  op = {4'hF, op[11:8], c8_pkg::KK_BCD};
      6:  op = {4'hF, op[11:8], c8_pkg::KK_STORE};
      7:  op = {4'hF, op[11:8], c8_pkg::KK_LOADR};
      8:  op = {4'hF, op[11:8], c8_pkg::KK_WKEY};
      9:  op = {4'hF, op[11:8], $urandom_range(0, 1) ? c8_pkg::KK_FONT : c8_pkg::KK_ADDI};
      10: op = {4'hE, op[11:8], $urandom_range(0, 1) ? c8_pkg::KK_SKP : c8_pkg::KK_SKNP};
      11: op = {4'hD, op[11:0]};
      12: op = {4'hA, op[11:0]};
      default: ;
    endcase
    return op;
  endfunction

  logic [15:0] op, kmask;
  bit gaps;

  initial begin
    rst = 1; s_tvalid = 0; s_tdata = '0; s_tuser = c8_pkg::REQ_LOAD;
    n_items = 0; rx_idle_on = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cur_pc = c8_pkg::PcReset;
    // directed: extremes and special cases
    read_px(8'd0, 0); read_px(8'd255, 0);
    exec_op(16'h6FFF, 0, 0);                 // vf = ff
    exec_op(16'h60FF, 0, 0);
    exec_op(16'h8F04, 0, 0);                 // add with x = f, result wins
    exec_op(16'h6138, 0, 0);
    exec_op(16'h6228, 0, 0);
    exec_op(16'hD12F, 0, 0);                 // draw at the right edge, y wraps to 8
    exec_op(16'hD12F, 0, 0);                 // same again for collision
    read_px(8'd255, 0);
    exec_op(16'h00E0, 0, 0);
    exec_op(16'hF00A, 16'h0000, 0);          // waits, no key
    exec_op(16'hF00A, 16'h8000, 0);
    exec_op(16'h63FF, 0, 0);
    exec_op(16'hE39E, 16'hFFFF, 0);          // key above 15 is not pressed
    exec_op(16'hE3A1, 16'hFFFF, 0);
    exec_op(16'hF318, 0, 0);
    exec_op(16'hF315, 0, 0);
    exec_op(16'hC3A5, 0, 0);
    exec_op(16'h8127, 0, 0);
    exec_op(16'h2FFE, 0, 0);                 // call to the top of memory
    exec_op(16'h00EE, 0, 0);
    exec_op(16'h00EE, 0, 0);                 // stack underflow wraps
    tick(0); tick(0);
    exec_op(16'hB0FF, 0, 0);
    // random part: mostly instructions with their code written just ahead
    for (int k = 0; n_items < 1300; k++) begin
      gaps = n_items < 1150;
      rx_idle_on = gaps;
      if (k == 100) begin
        s_tvalid <= 1'b0;
        @(posedge clk iff pending == 0);
        repeat ($urandom_range(5, 30)) @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0: tick(gaps);
        1: read_px(8'($urandom), gaps);
        2: exec_op(16'h6000 | 16'($urandom_range(0, 15)) << 8 | 16'($urandom_range(1, 8)),
                   0, gaps);  // short timer values for beeps
        default: begin
          op = random_op();
          kmask = $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom);
          exec_op(op, kmask, gaps);
        end
      endcase
    end
    s_tvalid <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (200) @(posedge clk);
    $display("sent %0d items, %0d results, %0d sprite draws, %0d beeps",
             n_items, result_count, draw_count, beep_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/c8_pkg.sv
rtl/c8_ram.sv
rtl/chip8_interpreter_core_top.sv
tb/chip8_checker.sv
tb/tb.sv
